>>> sv/dttl_pkg.sv
`default_nettype none

package dttl_pkg;

   localparam int NUM_CHANNELS = 22;
   localparam int CHAN_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int AMP_W = 12;

   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   localparam logic [2:0] KIND_TTL     = 3'd0;
   localparam logic [2:0] KIND_FREQ    = 3'd1;
   localparam logic [2:0] KIND_AMP     = 3'd2;
   localparam logic [2:0] KIND_PHASE   = 3'd3;
   localparam logic [2:0] KIND_RESET   = 3'd4;
   localparam logic [2:0] KIND_CLOCK   = 3'd5;
   localparam logic [2:0] KIND_REINIT  = 3'd6;
   localparam logic [2:0] KIND_IGNORED = 3'd7;

   localparam logic [3:0] OP_TTL   = 4'd0;
   localparam logic [3:0] OP_FSET  = 4'd1;
   localparam logic [3:0] OP_FGET  = 4'd2;
   localparam logic [3:0] OP_ASET  = 4'd3;
   localparam logic [3:0] OP_AGET  = 4'd4;
   localparam logic [3:0] OP_PSET  = 4'd5;
   localparam logic [3:0] OP_PGET  = 4'd6;
   localparam logic [3:0] OP_CLOCK = 4'd7;
   localparam logic [3:0] OP_CHECK = 4'd8;

   localparam logic [2:0] CSR_MIN_PULSE_TIME   = 3'd0;
   localparam logic [2:0] CSR_FREQ_WRITE_TIME  = 3'd1;
   localparam logic [2:0] CSR_AMP_WRITE_TIME   = 3'd2;
   localparam logic [2:0] CSR_PHASE_WRITE_TIME = 3'd3;
   localparam logic [2:0] CSR_CLOCK_WRITE_TIME = 3'd4;

   typedef struct packed {
      logic [2:0]  kind;
      logic [4:0]  channel_or_level;
      logic [31:0] value;
      logic        override_req;
      logic        wants_result;
   } req_type;

   typedef struct packed {
      logic        emit;
      logic [3:0]  pulser_op;
      logic [4:0]  out_channel;
      logic [31:0] out_value;
      logic [15:0] time_advance;
      logic        expects_result;
   } rsp_type;

   typedef struct packed {
      logic [15:0] min_pulse_time;
      logic [15:0] freq_write_time;
      logic [15:0] amp_write_time;
      logic [15:0] phase_write_time;
      logic [15:0] clock_write_time;
   } cfg_type;

endpackage

`default_nettype wire

>>> sv/dds_ttl_command_override_filter_core.sv
// Command filter for a pulse generator. Each command beat on req_ yields
// exactly one result beat on rsp_ (emit low when nothing is issued), in
// order. Throughput is one command per cycle unless a low rsp_ready stalls
// rsp_; a command passes the input register, then the result register, with
// the TTL word and the per-channel override store read, updated and written
// back as the result is registered. The csr_ port is always ready; index 0
// to 4 select min_pulse_time, freq_write_time, amp_write_time, phase_write_time
// and clock_write_time, other indices are dropped. Write it only while idle.
`default_nettype none

module dds_ttl_command_override_filter_core
   import dttl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   req_type req_ff;
   logic    req_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic    rsp_valid_ff;
   cfg_type cfg_ff;
   logic    advance;
   logic    fire;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid_ff && advance;
   assign req_ready = !req_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   dttl_cmd_unit u_cmd (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (req_ff),
      .cfg   (cfg_ff),
      .rsp   (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) req_valid_ff <= req_valid;
         if (advance) rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) req_ff <= req_data;
      if (fire) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MIN_PULSE_TIME:   cfg_ff.min_pulse_time   <= csr_data;
            CSR_FREQ_WRITE_TIME:  cfg_ff.freq_write_time  <= csr_data;
            CSR_AMP_WRITE_TIME:   cfg_ff.amp_write_time   <= csr_data;
            CSR_PHASE_WRITE_TIME: cfg_ff.phase_write_time <= csr_data;
            CSR_CLOCK_WRITE_TIME: cfg_ff.clock_write_time <= csr_data;
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> sv/dttl_cmd_unit.sv
`default_nettype none

module dttl_cmd_unit
   import dttl_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    fire,
   input  wire req_type req,
   input  wire cfg_type cfg,
   output rsp_type      rsp
);

   logic [31:0]      ttl_ff;
   logic [31:0]      ttl_in;
   logic [31:0]      freq_ov_ff [NUM_CHANNELS];
   logic [AMP_W-1:0] amp_ov_ff  [NUM_CHANNELS];
   logic             amp_on_ff  [NUM_CHANNELS];
   logic [15:0]      ph_ov_ff   [NUM_CHANNELS];
   logic             ph_on_ff   [NUM_CHANNELS];
   logic             pend_ff    [NUM_CHANNELS];

   logic              in_range;
   logic [CHAN_W-1:0] idx;
   logic [15:0]       v16;
   logic              ovr;
   logic              rd;
   logic              wr_en;

   logic [31:0]      f_cur, f_in;
   logic [AMP_W-1:0] a_cur, a_in;
   logic             a_on_cur, a_on_in;
   logic [15:0]      p_cur, p_in;
   logic             p_on_cur, p_on_in;
   logic             pend_cur, pend_in;

   assign in_range = 32'(req.channel_or_level) < NUM_CHANNELS;
   assign idx      = in_range ? req.channel_or_level[CHAN_W-1:0] : '0;
   assign v16      = req.value[15:0];
   assign ovr      = req.override_req;
   assign rd       = req.wants_result;

   assign f_cur    = freq_ov_ff[idx];
   assign a_cur    = amp_ov_ff[idx];
   assign a_on_cur = amp_on_ff[idx];
   assign p_cur    = ph_ov_ff[idx];
   assign p_on_cur = ph_on_ff[idx];
   assign pend_cur = pend_ff[idx];

   always_comb begin
      rsp     = '0;
      ttl_in  = ttl_ff;
      f_in    = f_cur;
      a_in    = a_cur;
      a_on_in = a_on_cur;
      p_in    = p_cur;
      p_on_in = p_on_cur;
      pend_in = pend_cur;
      wr_en   = 1'b0;
      unique case (req.kind)
         KIND_TTL: begin
            ttl_in           = (req.channel_or_level != 5'd0) ? (ttl_ff | req.value)
                                                             : (ttl_ff & ~req.value);
            rsp.emit         = 1'b1;
            rsp.pulser_op    = OP_TTL;
            rsp.out_value    = ttl_in;
            rsp.time_advance = cfg.min_pulse_time;
         end
         KIND_CLOCK: begin
            rsp.emit         = 1'b1;
            rsp.pulser_op    = OP_CLOCK;
            rsp.out_value    = {24'd0, req.value[7:0]};
            rsp.time_advance = cfg.clock_write_time;
         end
         KIND_FREQ: begin
            wr_en = in_range;
            if (in_range) begin
               rsp.out_channel  = req.channel_or_level;
               rsp.time_advance = cfg.freq_write_time;
               if (ovr || (f_cur != ALL_ONES && !rd)) begin
                  if (req.value != f_cur) begin
                     f_in = req.value;
                     if (req.value != ALL_ONES) begin
                        rsp.emit      = 1'b1;
                        rsp.pulser_op = OP_FSET;
                        rsp.out_value = req.value;
                     end
                  end
               end else if (!rd) begin
                  rsp.emit      = 1'b1;
                  rsp.pulser_op = OP_FSET;
                  rsp.out_value = req.value;
               end else begin
                  rsp.emit           = 1'b1;
                  rsp.pulser_op      = OP_FGET;
                  rsp.expects_result = 1'b1;
               end
            end
         end
         KIND_AMP: begin
            wr_en = in_range;
            if (in_range) begin
               rsp.out_channel  = req.channel_or_level;
               rsp.time_advance = cfg.amp_write_time;
               if (ovr || (a_on_cur && !rd)) begin
                  if (!(v16 == {{(16-AMP_W){1'b0}}, a_cur} && a_on_cur)) begin
                     if (req.value == ALL_ONES) begin
                        a_on_in = 1'b0;
                     end else begin
                        a_in          = v16[AMP_W-1:0];
                        a_on_in       = 1'b1;
                        rsp.emit      = 1'b1;
                        rsp.pulser_op = OP_ASET;
                        rsp.out_value = {16'd0, v16};
                     end
                  end
               end else if (!rd) begin
                  rsp.emit      = 1'b1;
                  rsp.pulser_op = OP_ASET;
                  rsp.out_value = {16'd0, v16};
               end else begin
                  rsp.emit           = 1'b1;
                  rsp.pulser_op      = OP_AGET;
                  rsp.expects_result = 1'b1;
               end
            end
         end
         KIND_PHASE: begin
            wr_en = in_range;
            if (in_range) begin
               rsp.out_channel  = req.channel_or_level;
               rsp.time_advance = cfg.phase_write_time;
               if (ovr || (p_on_cur && !rd)) begin
                  if (!(v16 == p_cur && p_on_cur)) begin
                     if (req.value == ALL_ONES) begin
                        p_on_in = 1'b0;
                     end else begin
                        p_in          = v16;
                        p_on_in       = 1'b1;
                        rsp.emit      = 1'b1;
                        rsp.pulser_op = OP_PSET;
                        rsp.out_value = {16'd0, v16};
                     end
                  end
               end else if (!rd) begin
                  rsp.emit      = 1'b1;
                  rsp.pulser_op = OP_PSET;
                  rsp.out_value = {16'd0, v16};
               end else begin
                  rsp.emit           = 1'b1;
                  rsp.pulser_op      = OP_PGET;
                  rsp.expects_result = 1'b1;
               end
            end
         end
         KIND_RESET: begin
            wr_en   = in_range;
            pend_in = 1'b1;
         end
         KIND_REINIT: begin
            wr_en = in_range;
            if (in_range) begin
               if (pend_cur) begin
                  f_in    = ALL_ONES;
                  a_on_in = 1'b0;
                  p_on_in = 1'b0;
               end
               pend_in         = 1'b0;
               rsp.emit        = 1'b1;
               rsp.pulser_op   = OP_CHECK;
               rsp.out_channel = req.channel_or_level;
               rsp.out_value   = {31'd0, pend_cur};
            end
         end
         KIND_IGNORED: begin
         end
      endcase
      // nothing issued: the whole beat reads as zero
      if (!rsp.emit) rsp = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            freq_ov_ff[i] <= ALL_ONES;
            amp_on_ff[i]  <= 1'b0;
            ph_on_ff[i]   <= 1'b0;
            pend_ff[i]    <= 1'b0;
         end
      end else if (fire) begin
         ttl_ff <= ttl_in;
         if (wr_en) begin
            freq_ov_ff[idx] <= f_in;
            amp_on_ff[idx]  <= a_on_in;
            ph_on_ff[idx]   <= p_on_in;
            pend_ff[idx]    <= pend_in;
         end
      end
   end

   // override values are only read while their enable is set
   always_ff @(posedge clock) begin
      if (fire && wr_en) begin
         amp_ov_ff[idx] <= a_in;
         ph_ov_ff[idx]  <= p_in;
      end
   end

endmodule

`default_nettype wire
